// ----- rtl/che_pkg.sv -----
package che_pkg;

  localparam int unsigned DEF_ALPHABET_SIZE = 256;
  localparam int unsigned DEF_MAX_LENGTH    = 32;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned LEN_FW = 6;
  localparam int unsigned ORD_W  = 9;
  localparam int unsigned CODE_W = 32;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_ENCODE = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ASSIGN,
    S_ORD,
    S_CODE
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [SYM_W-1:0]   symbol;
    logic [LEN_FW-1:0]  code_length;
    logic [ORD_W-1:0]   first_ordinal;
    logic [CODE_W-1:0]  first_code;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code_bits;
    logic [LEN_FW-1:0]  bit_count;
  } out_item_t;

endpackage

// ----- rtl/che_len_search.sv -----
module che_len_search #(
  parameter int unsigned MAX_LENGTH = che_pkg::DEF_MAX_LENGTH,
  localparam int unsigned LIDX_W    = $clog2(MAX_LENGTH),
  localparam int unsigned LEN_W     = $clog2(MAX_LENGTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [LIDX_W-1:0]         wr_idx_i,
  input  logic [che_pkg::ORD_W-1:0] wr_ord_i,
  input  logic [che_pkg::ORD_W-1:0] ord_i,
  input  logic [LEN_W-1:0]          max_len_i,
  output logic [LEN_W-1:0]          len_o
);
  import che_pkg::*;

  // Shadow of each row's first ordinal; one comparator lane per length below MAX_LENGTH.
  logic [ORD_W-1:0] bank_q [MAX_LENGTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bank_q[wr_idx_i] <= wr_ord_i;
    end
  end

  // Shortest length whose successor row starts above the ordinal, capped at max_len.
  always_comb begin
    len_o = LEN_W'(MAX_LENGTH);
    for (int k = int'(MAX_LENGTH) - 1; k >= 1; k--) begin
      if (k >= int'(max_len_i) || ord_i < bank_q[LIDX_W'(k)]) begin
        len_o = LEN_W'(k);
      end
    end
  end

endmodule

// ----- rtl/canonical_huffman_encoder.sv -----
// Load and finish transactions complete in the idle state; a finish result is registered as it is accepted.
// Assign reads the length's row, then writes back the symbol and row memories.
// Encode steps through a symbol memory read, a length search plus row memory read, and a code add.
// Encodes do not overlap: input is taken only in idle, after the code stage registers; a held
// result stalls the code stage. Reset clears the control state and sets max_code_len to 1;
// the symbol and row memories hold undefined contents until written, with no clearing pass.
module canonical_huffman_encoder #(
  parameter int unsigned ALPHABET_SIZE = che_pkg::DEF_ALPHABET_SIZE,
  parameter int unsigned MAX_LENGTH    = che_pkg::DEF_MAX_LENGTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [che_pkg::LEN_FW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  che_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output che_pkg::out_item_t         out_data_o
);
  import che_pkg::*;

  localparam int unsigned SIDX_W = $clog2(ALPHABET_SIZE);
  localparam int unsigned LIDX_W = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W  = $clog2(MAX_LENGTH + 1);

  typedef struct packed {
    logic [ORD_W-1:0]  first_ordinal;
    logic [CODE_W-1:0] first_code;
    logic [ORD_W-1:0]  next_ordinal;
  } row_t;

  state_e            state_q, state_d;
  in_item_t          item_q;
  logic [LEN_FW-1:0] max_code_len_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              out_valid_q;
  out_item_t         out_q, out_d;
  logic              out_load;

  // Symbol ordinal memory.
  logic [ORD_W-1:0]  sym_mem [ALPHABET_SIZE];
  logic [ORD_W-1:0]  sym_rdata_q;
  logic              sym_we, sym_re;
  logic [SIDX_W-1:0] sym_waddr, sym_raddr;
  logic [ORD_W-1:0]  sym_wdata;

  // Row memory: first ordinal, first code and next-ordinal counter of each length.
  row_t              row_mem [MAX_LENGTH];
  row_t              row_rdata_q;
  logic              row_we, row_re;
  logic [LIDX_W-1:0] row_waddr, row_raddr;
  row_t              row_wdata;
  logic              bank_we;

  logic              in_fire;
  logic              slot_free;
  logic              len_ok;
  logic              sym_ok;
  logic [LIDX_W-1:0] in_lidx;
  logic [SIDX_W-1:0] in_sidx;
  logic [LEN_W-1:0]  eff_max;
  logic [LEN_W-1:0]  search_len;
  logic [CODE_W-1:0] code_sum;
  logic [CODE_W-1:0] code_mask;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign len_ok    = (in_data_i.code_length != '0) &&
                     (32'(in_data_i.code_length) <= 32'(MAX_LENGTH));
  assign sym_ok    = 32'(in_data_i.symbol) < 32'(ALPHABET_SIZE);
  assign in_lidx   = LIDX_W'(in_data_i.code_length - LEN_FW'(1));
  assign in_sidx   = SIDX_W'(in_data_i.symbol);

  always_comb begin
    if (max_code_len_q == '0) begin
      eff_max = LEN_W'(1);
    end else if (32'(max_code_len_q) > 32'(MAX_LENGTH)) begin
      eff_max = LEN_W'(MAX_LENGTH);
    end else begin
      eff_max = LEN_W'(max_code_len_q);
    end
  end

  che_len_search #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_len_search (
    .clk_i    (clk_i),
    .wr_en_i  (bank_we),
    .wr_idx_i (row_waddr),
    .wr_ord_i (in_data_i.first_ordinal),
    .ord_i    (sym_rdata_q),
    .max_len_i(eff_max),
    .len_o    (search_len)
  );

  assign code_sum  = (CODE_W'(sym_rdata_q) - CODE_W'(row_rdata_q.first_ordinal)) +
                     row_rdata_q.first_code;
  assign code_mask = (32'(len_q) >= CODE_W) ? '1 :
                     ((CODE_W'(1) << len_q) - CODE_W'(1));

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    out_d      = out_q;
    sym_we     = 1'b0;
    sym_waddr  = SIDX_W'(item_q.symbol);
    sym_wdata  = row_rdata_q.next_ordinal;
    sym_re     = 1'b0;
    sym_raddr  = in_sidx;
    row_we     = 1'b0;
    row_waddr  = in_lidx;
    row_wdata  = '{first_ordinal: in_data_i.first_ordinal, first_code: in_data_i.first_code,
                   next_ordinal: in_data_i.first_ordinal};
    row_re     = 1'b0;
    row_raddr  = in_lidx;
    bank_we    = 1'b0;

    case (state_q)
      S_IDLE: begin
        // Hold a finish transaction until the output register can take it.
        in_ready_o = (in_data_i.cmd != CMD_FINISH) || slot_free;
        if (in_fire) begin
          case (in_data_i.cmd)
            CMD_LOAD: begin
              if (len_ok) begin
                row_we  = 1'b1;
                bank_we = 1'b1;
              end
            end
            CMD_ASSIGN: begin
              if (len_ok && sym_ok) begin
                row_re  = 1'b1;
                state_d = S_ASSIGN;
              end
            end
            CMD_ENCODE: begin
              if (sym_ok) begin
                sym_re  = 1'b1;
                state_d = S_ORD;
              end
            end
            CMD_FINISH: begin
              out_load = 1'b1;
              out_d    = '{code_bits: '0, bit_count: LEN_FW'(eff_max)};
            end
            default: ;
          endcase
        end
      end
      S_ASSIGN: begin
        // Write the symbol's ordinal, and write the row back with its counter advanced.
        sym_we    = 1'b1;
        row_we    = 1'b1;
        row_waddr = LIDX_W'(item_q.code_length - LEN_FW'(1));
        row_wdata = '{first_ordinal: row_rdata_q.first_ordinal,
                      first_code: row_rdata_q.first_code,
                      next_ordinal: row_rdata_q.next_ordinal + ORD_W'(1)};
        state_d   = S_IDLE;
      end
      S_ORD: begin
        row_re    = 1'b1;
        row_raddr = LIDX_W'(search_len - LEN_W'(1));
        len_d     = search_len;
        state_d   = S_CODE;
      end
      S_CODE: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_d    = '{code_bits: code_sum & code_mask, bit_count: LEN_FW'(len_q)};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      max_code_len_q <= LEN_FW'(1);
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_code_len_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    if (sym_re) begin
      sym_rdata_q <= sym_mem[sym_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rdata_q <= row_mem[row_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input ready outside idle");

  a_assign_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ASSIGN |=> state_q == S_IDLE)
    else $error("assign write-back did not return to idle");

  a_ord_to_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ORD |=> state_q == S_CODE)
    else $error("length search did not advance to code stage");

  a_code_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CODE && slot_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("encode result not registered");

  a_finish_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.cmd == CMD_FINISH) |=>
      out_valid_q && out_q.code_bits == '0 &&
      out_q.bit_count == $past(LEN_FW'(eff_max)))
    else $error("finish marker wrong");

endmodule
